// ===== rtl/core/audio_format_descriptor_parser_macros.svh =====
// Assertion helpers shared by the parser RTL.
`ifndef AUDIO_FORMAT_DESCRIPTOR_PARSER_MACROS_SVH
`define AUDIO_FORMAT_DESCRIPTOR_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define AFDP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afdp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define AFDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afdp next-cycle check failed");

`else

`define AFDP_ASSERT_NOW(label, clk, rst, ante, cons)
`define AFDP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/afdp_pkg.sv =====
`default_nettype none
package afdp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_CMP,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    SRC_DESC    = 2'd0,
    SRC_INFER   = 2'd1,
    SRC_DEFAULT = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    PICK_NONE,
    PICK_DESC,
    PICK_INFER,
    PICK_DEFAULT
  } pick_t;

  typedef struct packed {
    logic  take;
    logic  prep;
    logic  mul;
    logic  step;
    pick_t pick;
    logic  load_out;
    logic  clear;
  } cmd_t;

  typedef struct packed {
    logic found_nz;
    logic kept_zero;
    logic match;
    logic idx_last;
  } status_t;

  localparam logic [7:0]  AUDIO_CS_TYPE  = 8'h24;
  localparam logic [7:0]  FORMAT_SUBTYPE = 8'h02;
  localparam logic [7:0]  FORMAT_TYPE_I  = 8'h01;
  localparam logic [7:0]  MIN_DESC_LEN   = 8'd2;
  localparam logic [7:0]  FMT_MIN_LEN    = 8'd8;

  localparam logic [7:0]  OFF_LENGTH     = 8'd0;
  localparam logic [7:0]  OFF_TYPE       = 8'd1;
  localparam logic [7:0]  OFF_SUBTYPE    = 8'd2;
  localparam logic [7:0]  OFF_FORMAT     = 8'd3;
  localparam logic [7:0]  OFF_CHANNELS   = 8'd4;
  localparam logic [7:0]  OFF_SUBFRAME   = 8'd5;
  localparam logic [7:0]  OFF_FREQ_COUNT = 8'd7;
  localparam logic [7:0]  OFF_FREQ_LIST  = 8'd8;

  localparam logic [21:0] FRAME_DIV      = 22'd1000;
  localparam logic [24:0] UFRAME_DIV     = 25'd8000;
  localparam logic [23:0] DEFAULT_RATE   = 24'd48000;
  localparam logic [2:0]  LAST_RATE_IDX  = 3'd7;

  function automatic logic [18:0] std_rate(input logic [2:0] idx);
    logic [18:0] r;
    case (idx)
      3'd0:    r = 19'd44100;
      3'd1:    r = 19'd48000;
      3'd2:    r = 19'd88200;
      3'd3:    r = 19'd96000;
      3'd4:    r = 19'd176400;
      3'd5:    r = 19'd192000;
      3'd6:    r = 19'd352800;
      3'd7:    r = 19'd384000;
      default: r = 19'd48000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/afdp_in_if.sv =====
`default_nettype none
interface afdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       last_byte;

  modport source (output valid, output desc_byte, output last_byte, input ready);
  modport sink   (input valid, input desc_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/afdp_out_if.sv =====
`default_nettype none
interface afdp_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] sample_rate;
  logic [7:0]  channel_count;
  logic [7:0]  subframe_bytes;
  logic [1:0]  rate_source;

  modport source (
    output valid, output sample_rate, output channel_count,
    output subframe_bytes, output rate_source, input ready
  );
  modport sink (
    input valid, input sample_rate, input channel_count,
    input subframe_bytes, input rate_source, output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/afdp_ctrl.sv =====
`default_nettype none
module afdp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  input  wire logic              out_ready,
  output logic                   out_valid,
  input  wire afdp_pkg::status_t status,
  output afdp_pkg::cmd_t         cmd
);
  import afdp_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.pick   = PICK_NONE;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && in_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.prep = 1'b1;
        if (status.found_nz) begin
          cmd.pick   = PICK_DESC;
          state_next = ST_FINISH;
        end else if (status.kept_zero) begin
          cmd.pick   = PICK_DEFAULT;
          state_next = ST_FINISH;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (status.match) begin
          cmd.pick   = PICK_INFER;
          state_next = ST_FINISH;
        end else if (status.idx_last) begin
          cmd.pick   = PICK_DEFAULT;
          state_next = ST_FINISH;
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_FINISH: begin
        // Wait here only if the previous result has not been taken yet.
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/afdp_dp.sv =====
`default_nettype none
module afdp_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [11:0]    cfg_wdata,
  input  wire logic [7:0]     desc_byte,
  input  wire afdp_pkg::cmd_t cmd,
  output afdp_pkg::status_t   status,
  output logic [23:0]         sample_rate,
  output logic [7:0]          channel_count,
  output logic [7:0]          subframe_bytes,
  output logic [1:0]          rate_source
);
  import afdp_pkg::*;

  logic [11:0] packet_size;

  // Descriptor walk state.
  logic [7:0]  off,   off_next;
  logic [7:0]  dlen,  dlen_next;
  logic        halted, halted_next;
  logic        hdr,   hdr_next;
  logic [7:0]  pch,   pch_next;
  logic [7:0]  psub,  psub_next;
  logic [7:0]  pcnt,  pcnt_next;
  logic [23:0] prate, prate_next;
  logic [23:0] found, found_next;
  logic [7:0]  kch,   kch_next;
  logic [7:0]  ksub,  ksub_next;

  // Rate search.
  logic [15:0] chsub;
  logic [21:0] lo_frame, hi_frame;
  logic [24:0] lo_uframe, hi_uframe;
  logic [34:0] prod;
  logic [2:0]  idx;
  logic [12:0] ps_inc;

  logic [23:0] res_rate;
  src_t        res_src;

  logic [9:0]  off_ext;
  logic [9:0]  list_start;
  logic [9:0]  byte_pos;
  logic [9:0]  list_end;
  logic        in_list;
  logic        desc_done;

  always_comb begin
    off_ext    = {2'b00, off};
    list_start = {2'b00, pcnt} + {1'b0, pcnt, 1'b0} + 10'd5;
    byte_pos   = off_ext - list_start;
    in_list    = (off >= OFF_FREQ_LIST) && (pcnt != 8'd0) &&
                 (off_ext >= list_start) && (byte_pos < 10'd3);
  end

  always_comb begin
    off_next    = off;
    dlen_next   = dlen;
    halted_next = halted;
    hdr_next    = hdr;
    pch_next    = pch;
    psub_next   = psub;
    pcnt_next   = pcnt;
    prate_next  = prate;
    found_next  = found;
    kch_next    = kch;
    ksub_next   = ksub;
    desc_done   = 1'b0;
    list_end    = '0;
    if (cmd.clear) begin
      off_next    = '0;
      dlen_next   = '0;
      halted_next = 1'b0;
      hdr_next    = 1'b0;
      pch_next    = '0;
      psub_next   = '0;
      pcnt_next   = '0;
      prate_next  = '0;
      found_next  = '0;
    end else if (cmd.take && !halted) begin
      if (off == OFF_LENGTH && desc_byte < MIN_DESC_LEN) begin
        halted_next = 1'b1;
      end else begin
        if (off == OFF_LENGTH) begin
          dlen_next  = desc_byte;
          hdr_next   = 1'b0;
          prate_next = '0;
          pcnt_next  = '0;
        end else if (off == OFF_TYPE) begin
          hdr_next = (desc_byte == AUDIO_CS_TYPE);
        end else if (off == OFF_SUBTYPE) begin
          hdr_next = hdr && (desc_byte == FORMAT_SUBTYPE);
        end else if (off == OFF_FORMAT) begin
          hdr_next = hdr && (desc_byte == FORMAT_TYPE_I);
        end else if (off == OFF_CHANNELS) begin
          pch_next = desc_byte;
        end else if (off == OFF_SUBFRAME) begin
          psub_next = desc_byte;
        end else if (off == OFF_FREQ_COUNT) begin
          pcnt_next = desc_byte;
        end else if (in_list) begin
          case (byte_pos[1:0])
            2'd0:    prate_next[7:0]   = prate[7:0]   | desc_byte;
            2'd1:    prate_next[15:8]  = prate[15:8]  | desc_byte;
            2'd2:    prate_next[23:16] = prate[23:16] | desc_byte;
            default: prate_next        = prate;
          endcase
        end

        desc_done = ({1'b0, off} + 9'd1) >= {1'b0, dlen_next};
        list_end  = {2'b00, pcnt_next} + {1'b0, pcnt_next, 1'b0} + 10'd8;
        if (desc_done) begin
          off_next = '0;
          if (hdr_next && dlen_next >= FMT_MIN_LEN) begin
            kch_next  = pch_next;
            ksub_next = psub_next;
            // The rate counts only when the whole frequency list fits.
            if (pcnt_next != 8'd0 && {2'b00, dlen_next} >= list_end) begin
              found_next = prate_next;
            end
          end
        end else begin
          off_next = off + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_size <= '0;
      off         <= '0;
      dlen        <= '0;
      halted      <= 1'b0;
      hdr         <= 1'b0;
      pch         <= '0;
      psub        <= '0;
      pcnt        <= '0;
      prate       <= '0;
      found       <= '0;
      kch         <= 8'd2;
      ksub        <= 8'd2;
    end else begin
      if (cfg_we) begin
        packet_size <= cfg_wdata;
      end
      off    <= off_next;
      dlen   <= dlen_next;
      halted <= halted_next;
      hdr    <= hdr_next;
      pch    <= pch_next;
      psub   <= psub_next;
      pcnt   <= pcnt_next;
      prate  <= prate_next;
      found  <= found_next;
      kch    <= kch_next;
      ksub   <= ksub_next;
    end
  end

  assign ps_inc = {1'b0, packet_size} + 13'd1;

  // A product p gives p / d == packet_size exactly when
  // packet_size * d <= p < (packet_size + 1) * d.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      chsub     <= {8'd0, kch} * {8'd0, ksub};
      lo_frame  <= {10'd0, packet_size} * FRAME_DIV;
      hi_frame  <= {9'd0, ps_inc} * FRAME_DIV;
      lo_uframe <= {13'd0, packet_size} * UFRAME_DIV;
      hi_uframe <= {12'd0, ps_inc} * UFRAME_DIV;
      idx       <= '0;
    end else if (cmd.step) begin
      idx <= idx + 3'd1;
    end
    if (cmd.mul) begin
      prod <= {16'd0, std_rate(idx)} * {19'd0, chsub};
    end
    case (cmd.pick)
      PICK_DESC: begin
        res_rate <= found;
        res_src  <= SRC_DESC;
      end
      PICK_INFER: begin
        res_rate <= {5'd0, std_rate(idx)};
        res_src  <= SRC_INFER;
      end
      PICK_DEFAULT: begin
        res_rate <= DEFAULT_RATE;
        res_src  <= SRC_DEFAULT;
      end
      default: begin
        res_rate <= res_rate;
        res_src  <= res_src;
      end
    endcase
    if (cmd.load_out) begin
      sample_rate    <= res_rate;
      channel_count  <= kch;
      subframe_bytes <= ksub;
      rate_source    <= res_src;
    end
  end

  always_comb begin
    status.found_nz  = (found != 24'd0);
    status.kept_zero = (kch == 8'd0) || (ksub == 8'd0);
    status.match     = ((prod >= {13'd0, lo_frame}) && (prod < {13'd0, hi_frame})) ||
                       ((prod >= {10'd0, lo_uframe}) && (prod < {10'd0, hi_uframe}));
    status.idx_last  = (idx == LAST_RATE_IDX);
  end

endmodule
`default_nettype wire

// ===== rtl/core/audio_format_descriptor_parser.sv =====
// Channel   Dir   Payload                                                 Beat when
// desc      in    desc_byte[7:0], last_byte                               valid && ready
// result    out   sample_rate[23:0], channel_count[7:0],
//                 subframe_bytes[7:0], rate_source[1:0]                   valid && ready
// cfg       in    cfg_wdata[11:0] (packet size)                           cfg_we
//
// Ordinary descriptor bytes are taken one per cycle.
// After a last byte, desc.ready stays low through the decide and finish states
// for a rate from a descriptor or the default, and also through the packet-size
// search: a multiply and a compare step for each of the eight standard rates tried.
// A finished result sits in an output register; a new stream can start while it
// waits, and only the next stream's result holds off until it is taken.
// Reset is synchronous; channel count and subframe size reset to 2 and persist
// across streams, while the walk state clears after each result.
`default_nettype none
`include "audio_format_descriptor_parser_macros.svh"
module audio_format_descriptor_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,
  afdp_in_if.sink          desc,
  afdp_out_if.source       result
);
  import afdp_pkg::*;

  cmd_t    cmd;
  status_t status;

  afdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (desc.valid),
    .in_last   (desc.last_byte),
    .in_ready  (desc.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .status    (status),
    .cmd       (cmd)
  );

  afdp_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .desc_byte      (desc.desc_byte),
    .cmd            (cmd),
    .status         (status),
    .sample_rate    (result.sample_rate),
    .channel_count  (result.channel_count),
    .subframe_bytes (result.subframe_bytes),
    .rate_source    (result.rate_source)
  );

  `AFDP_ASSERT_NEXT(a_last_blocks_input, clk, rst, desc.valid && desc.ready && desc.last_byte, !desc.ready)
  `AFDP_ASSERT_NOW(a_desc_rate_nonzero, clk, rst, result.valid && result.rate_source == SRC_DESC, result.sample_rate != 24'd0)
  `AFDP_ASSERT_NOW(a_default_rate, clk, rst, result.valid && result.rate_source == SRC_DEFAULT, result.sample_rate == DEFAULT_RATE)

endmodule
`default_nettype wire
